### hw/rtl/imuta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU time aligner package
// Shared constants for the aligner core and its serial fraction divider.
// ----------------------------------------------------------------------------
package imuta_pkg;

    // Width of the unsigned Q0.16 interpolation fraction.
    localparam int FRAC_BITS = 16;

    // Number of vector axes.
    localparam int AXES = 3;

endpackage

### hw/rtl/imuta_frac_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU time aligner fraction divider
// Restoring divider that forms floor(num * 2^16 / den) one bit per cycle.
// The numerator must be below the denominator.
// ----------------------------------------------------------------------------
module imuta_frac_div #(
    parameter int TIME_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [TIME_BITS-1:0]           i_num,
    input  logic [TIME_BITS-1:0]           i_den,
    output logic                           o_done,
    output logic [imuta_pkg::FRAC_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(imuta_pkg::FRAC_BITS + 1);

    logic [TIME_BITS-1:0]            r_rem;
    logic [TIME_BITS-1:0]            r_den;
    logic [imuta_pkg::FRAC_BITS-1:0] r_quot;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [TIME_BITS:0]              w_shift;
    logic                            w_fit;

    // One trial subtraction of the doubled remainder.
    assign w_shift = {r_rem, 1'b0};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(imuta_pkg::FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= TIME_BITS'(w_shift - {1'b0, r_den});
            end else begin
                r_rem <= w_shift[TIME_BITS-1:0];
            end
            r_quot <= {r_quot[imuta_pkg::FRAC_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hw/rtl/imu_gyro_accel_time_aligner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU gyro/accel time aligner core
// Joins gyro samples with accel vectors interpolated at the gyro time.
// ----------------------------------------------------------------------------
// Usage: samples enter on the s_axis channel, one transaction per sample;
// tuser bit 0 flags a gyro vector and bit 1 an accel vector. A sample with
// both is passed straight to m_axis. A sample with one vector goes into that
// sensor's history and a sequencer then scans the gyro history, comparing
// every stored accel entry against each candidate gyro time one per cycle.
// A match joins the gyro vector with the accel vector at equal time, or
// with one interpolated from the bracketing accel entries through a
// serial divider and one shared multiplier used for three axes.
// A pass-through sample goes from the idle state to the emit state, which
// loads the output register. A history sample is scanned through the gyro
// and accel histories; a bracket then runs the load, divide and multiply
// states. A match ends in the emit state. s_axis_tready is high only while
// the sequencer is idle. Results wait in an output register; while it is
// full and m_axis_tready is low the sequencer holds until the register
// frees. Reset empties both histories and clears the last sent time to zero.
// ----------------------------------------------------------------------------
module imu_gyro_accel_time_aligner_core #(
    parameter int HISTORY_DEPTH = 5,
    parameter int TIME_BITS     = 48,
    parameter int SAMPLE_BITS   = 16,
    localparam int DATA_W = ((TIME_BITS + 6 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // sample_time, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, zero pad
    input  logic [DATA_W-1:0] s_axis_tdata,
    // gyro present flag, accel present flag
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // joined_time, out_gyro_x/y/z, out_accel_x/y/z, zero pad
    output logic [DATA_W-1:0] m_axis_tdata
);

    localparam int IW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int VW    = 3 * SAMPLE_BITS;
    localparam int FB    = imuta_pkg::FRAC_BITS;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int PW    = FB + 1 + DW;
    localparam int SW    = PW - FB;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GSCAN = 9'b000000010,
        S_ASCAN = 9'b000000100,
        S_EQ    = 9'b000001000,
        S_LO    = 9'b000010000,
        S_UP    = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state r_state;

    // Histories, entry 0 oldest.
    logic [TIME_BITS-1:0] r_g_time [HISTORY_DEPTH];
    logic [VW-1:0]        r_g_vec  [HISTORY_DEPTH];
    logic [TIME_BITS-1:0] r_a_time [HISTORY_DEPTH];
    logic [VW-1:0]        r_a_vec  [HISTORY_DEPTH];
    logic [CW-1:0]        r_g_fill;
    logic [CW-1:0]        r_a_fill;
    logic [TIME_BITS-1:0] r_last;

    // Scan and working registers.
    logic [CW-1:0]        r_gi;
    logic [CW-1:0]        r_ai;
    logic                 r_eq_v, r_lo_v, r_up_v;
    logic [IW-1:0]        r_eq_i, r_lo_i, r_up_i;
    logic [TIME_BITS-1:0] r_gt;
    logic [VW-1:0]        r_gv;
    logic [VW-1:0]        r_acc;
    logic [TIME_BITS-1:0] r_lo_t;
    logic [VW-1:0]        r_lo_vec;
    logic [VW-1:0]        r_up_vec;
    logic [1:0]           r_ax;
    logic                 r_phase;
    logic signed [PW-1:0] r_prod;
    logic                 r_div_go;

    logic                 r_ovalid;
    logic [DATA_W-1:0]    r_odata;

    // Divider connections.
    logic [TIME_BITS-1:0] r_num, r_den;
    logic                 w_div_done;
    logic [FB-1:0]        w_frac;

    // Input decode.
    logic                   w_in_acc;
    logic                   w_hg, w_ha;
    logic [TIME_BITS-1:0]   w_in_t;
    logic [VW-1:0]          w_in_gv, w_in_av;
    logic                   w_out_free;
    logic [IW-1:0]          w_gidx, w_aidx;
    logic [TIME_BITS-1:0]   w_at;

    // Interpolation datapath.
    logic signed [SAMPLE_BITS-1:0] w_lo_s, w_up_s;
    logic signed [DW-1:0]          w_diff;
    logic signed [PW-1:0]          w_mul;
    logic signed [SW-1:0]          w_step;
    logic signed [SW-1:0]          w_sum;

    assign w_in_acc   = s_axis_tvalid & s_axis_tready;
    assign w_hg       = s_axis_tuser[0];
    assign w_ha       = s_axis_tuser[1];
    assign w_in_t     = s_axis_tdata[TIME_BITS-1:0];
    assign w_in_gv    = s_axis_tdata[TIME_BITS +: VW];
    assign w_in_av    = s_axis_tdata[TIME_BITS + VW +: VW];
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_gidx     = r_gi[IW-1:0];
    assign w_aidx     = r_ai[IW-1:0];
    assign w_at       = r_a_time[w_aidx];

    assign s_axis_tready = (r_state == S_IDLE);

    // Axis selection for the shared multiplier.
    always_comb begin
        case (r_ax)
            2'd0: begin
                w_lo_s = r_lo_vec[0 +: SAMPLE_BITS];
                w_up_s = r_up_vec[0 +: SAMPLE_BITS];
            end
            2'd1: begin
                w_lo_s = r_lo_vec[SAMPLE_BITS +: SAMPLE_BITS];
                w_up_s = r_up_vec[SAMPLE_BITS +: SAMPLE_BITS];
            end
            default: begin
                w_lo_s = r_lo_vec[2 * SAMPLE_BITS +: SAMPLE_BITS];
                w_up_s = r_up_vec[2 * SAMPLE_BITS +: SAMPLE_BITS];
            end
        endcase
    end

    assign w_diff = DW'(w_up_s) - DW'(w_lo_s);
    assign w_mul  = $signed({1'b0, w_frac}) * w_diff;
    assign w_step = r_prod[PW-1:FB];
    assign w_sum  = SW'(w_lo_s) + w_step;

    imuta_frac_div #(
        .TIME_BITS(TIME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_frac)
    );

    // History storage: push with shift when full.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_hg != w_ha)) begin
            if (w_hg) begin
                if (r_g_fill == CW'(HISTORY_DEPTH)) begin
                    for (int i = 1; i < HISTORY_DEPTH; i++) begin
                        r_g_time[i-1] <= r_g_time[i];
                        r_g_vec[i-1]  <= r_g_vec[i];
                    end
                    r_g_time[HISTORY_DEPTH-1] <= w_in_t;
                    r_g_vec[HISTORY_DEPTH-1]  <= w_in_gv;
                end else begin
                    r_g_time[r_g_fill[IW-1:0]] <= w_in_t;
                    r_g_vec[r_g_fill[IW-1:0]]  <= w_in_gv;
                end
            end else begin
                if (r_a_fill == CW'(HISTORY_DEPTH)) begin
                    for (int i = 1; i < HISTORY_DEPTH; i++) begin
                        r_a_time[i-1] <= r_a_time[i];
                        r_a_vec[i-1]  <= r_a_vec[i];
                    end
                    r_a_time[HISTORY_DEPTH-1] <= w_in_t;
                    r_a_vec[HISTORY_DEPTH-1]  <= w_in_av;
                end else begin
                    r_a_time[r_a_fill[IW-1:0]] <= w_in_t;
                    r_a_vec[r_a_fill[IW-1:0]]  <= w_in_av;
                end
            end
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_g_fill <= '0;
            r_a_fill <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
            r_gi     <= '0;
            r_ai     <= '0;
            r_eq_v   <= 1'b0;
            r_lo_v   <= 1'b0;
            r_up_v   <= 1'b0;
            r_ax     <= '0;
            r_phase  <= 1'b0;
        end else begin
            // The divider starts on the cycle after its operands are loaded.
            r_div_go <= (r_state == S_UP);
            // The output register loads from the emit state and frees on a transaction.
            if ((r_state == S_EMIT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_hg && w_ha) begin
                            r_state <= S_EMIT;
                        end else if (w_hg) begin
                            if (r_g_fill != CW'(HISTORY_DEPTH)) begin
                                r_g_fill <= r_g_fill + 1'b1;
                            end
                            r_gi    <= '0;
                            r_state <= S_GSCAN;
                        end else if (w_ha) begin
                            if (r_a_fill != CW'(HISTORY_DEPTH)) begin
                                r_a_fill <= r_a_fill + 1'b1;
                            end
                            r_gi    <= '0;
                            r_state <= S_GSCAN;
                        end
                    end
                end
                S_GSCAN: begin
                    if (r_gi == r_g_fill) begin
                        r_state <= S_IDLE;
                    end else if (r_g_time[w_gidx] <= r_last) begin
                        r_gi <= r_gi + 1'b1;
                    end else begin
                        r_ai    <= '0;
                        r_eq_v  <= 1'b0;
                        r_lo_v  <= 1'b0;
                        r_up_v  <= 1'b0;
                        r_state <= S_ASCAN;
                    end
                end
                S_ASCAN: begin
                    if (r_ai == r_a_fill) begin
                        if (r_eq_v) begin
                            r_state <= S_EQ;
                        end else if (r_lo_v && r_up_v) begin
                            r_state <= S_LO;
                        end else begin
                            r_gi    <= r_gi + 1'b1;
                            r_state <= S_GSCAN;
                        end
                    end else begin
                        if (w_at == r_gt) begin
                            r_eq_v <= 1'b1;
                        end else if (w_at < r_gt) begin
                            r_lo_v <= 1'b1;
                        end else if (!r_up_v) begin
                            r_up_v <= 1'b1;
                        end
                        r_ai <= r_ai + 1'b1;
                    end
                end
                S_EQ: begin
                    r_state <= S_EMIT;
                end
                S_LO: begin
                    r_state <= S_UP;
                end
                S_UP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ax    <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        if (r_ax == 2'(imuta_pkg::AXES - 1)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_last   <= r_gt;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_gt  <= w_in_t;
                r_gv  <= w_in_gv;
                r_acc <= w_in_av;
            end
            S_GSCAN: begin
                r_gt <= r_g_time[w_gidx];
                r_gv <= r_g_vec[w_gidx];
            end
            S_ASCAN: begin
                if (r_ai != r_a_fill) begin
                    if (w_at == r_gt) begin
                        r_eq_i <= w_aidx;
                    end else if (w_at < r_gt) begin
                        r_lo_i <= w_aidx;
                    end else if (!r_up_v) begin
                        r_up_i <= w_aidx;
                    end
                end
            end
            S_EQ: begin
                r_acc <= r_a_vec[r_eq_i];
            end
            S_LO: begin
                r_lo_t   <= r_a_time[r_lo_i];
                r_lo_vec <= r_a_vec[r_lo_i];
            end
            S_UP: begin
                r_up_vec <= r_a_vec[r_up_i];
                r_num    <= r_gt - r_lo_t;
                r_den    <= r_a_time[r_up_i] - r_lo_t;
            end
            S_MUL: begin
                if (!r_phase) begin
                    r_prod <= w_mul;
                end else begin
                    r_acc[r_ax * SAMPLE_BITS +: SAMPLE_BITS] <= w_sum[SAMPLE_BITS-1:0];
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_odata <= DATA_W'({r_acc, r_gv, r_gt});
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

### verif/tb_imu_gyro_accel_time_aligner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IMU gyro/accel time aligner core
// Drives random and directed IMU samples with random idling and checks every
// joined sample against a predictor of the aligner kept in a scoreboard.
// ----------------------------------------------------------------------------

// Predictor of the aligner plus the queue of joined samples it expects.
class joined_sample_board;
    localparam int DEPTH = 5;
    localparam int DW = 144;

    logic [47:0] gyro_t[DEPTH];
    logic signed [15:0] gyro_v[DEPTH][3];
    int gyro_n;
    logic [47:0] accel_t[DEPTH];
    logic signed [15:0] accel_v[DEPTH][3];
    int accel_n;
    logic [47:0] last_sent;
    logic [DW-1:0] pending_joins[$];
    int errors;

    function new();
        gyro_n = 0;
        accel_n = 0;
        last_sent = '0;
        errors = 0;
    endfunction

    // Packs one joined sample the way the master side carries it.
    function logic [DW-1:0] pack_join(logic [47:0] t, logic signed [15:0] g[3],
                                      logic signed [15:0] a[3]);
        return {a[2], a[1], a[0], g[2], g[1], g[0], t};
    endfunction

    // Q0.16 fraction of num/den, truncated; num < den always.
    function logic [15:0] frac_of(logic [47:0] num, logic [47:0] den);
        logic [64:0] n;
        n = {num, 16'h0};
        return 16'(n / den);
    endfunction

    // Linear interpolation with an arithmetic shift (floor).
    function logic signed [15:0] lerp(logic signed [15:0] lo, logic signed [15:0] up,
                                      logic [15:0] f);
        longint p;
        p = longint'({1'b0, f}) * (longint'(up) - longint'(lo));
        return 16'(longint'(lo) + (p >>> 16));
    endfunction

    // Notes one accepted sample and predicts the joined sample it causes.
    function void note_sample(logic hg, logic ha, logic [47:0] t,
                              logic signed [15:0] g[3], logic signed [15:0] a[3]);
        logic signed [15:0] acc[3];
        logic [15:0] f;
        int eq, lo, up;
        if (hg && ha) begin
            pending_joins = {pending_joins, pack_join(t, g, a)};
            last_sent = t;
            return;
        end
        if (!hg && !ha) return;
        // Push into the history, dropping the oldest entry when full.
        if (hg) begin
            if (gyro_n == DEPTH) begin
                for (int i = 1; i < DEPTH; i++) begin
                    gyro_t[i-1] = gyro_t[i];
                    gyro_v[i-1] = gyro_v[i];
                end
                gyro_n--;
            end
            gyro_t[gyro_n] = t;
            gyro_v[gyro_n] = g;
            gyro_n++;
        end else begin
            if (accel_n == DEPTH) begin
                for (int i = 1; i < DEPTH; i++) begin
                    accel_t[i-1] = accel_t[i];
                    accel_v[i-1] = accel_v[i];
                end
                accel_n--;
            end
            accel_t[accel_n] = t;
            accel_v[accel_n] = a;
            accel_n++;
        end
        // Oldest fresh gyro entry with an equal or bracketing accel entry.
        for (int gi = 0; gi < gyro_n; gi++) begin
            if (gyro_t[gi] <= last_sent) continue;
            eq = -1;
            lo = -1;
            up = -1;
            for (int ai = 0; ai < accel_n; ai++) begin
                if (accel_t[ai] == gyro_t[gi]) eq = ai;
                else if (accel_t[ai] < gyro_t[gi]) lo = ai;
                else if (up < 0) up = ai;
            end
            if (eq >= 0) begin
                acc = accel_v[eq];
            end else if (lo >= 0 && up >= 0) begin
                f = frac_of(gyro_t[gi] - accel_t[lo], accel_t[up] - accel_t[lo]);
                for (int k = 0; k < 3; k++) acc[k] = lerp(accel_v[lo][k], accel_v[up][k], f);
            end else begin
                continue;
            end
            pending_joins = {pending_joins, pack_join(gyro_t[gi], gyro_v[gi], acc)};
            last_sent = gyro_t[gi];
            return;
        end
    endfunction

    // Compares one joined sample with the oldest expectation.
    function void check_join(logic [DW-1:0] got);
        logic [DW-1:0] want;
        if (pending_joins.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected joined sample %h", got);
            return;
        end
        want = pending_joins[0];
        pending_joins.delete(0);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("joined sample mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb_imu_gyro_accel_time_aligner_core;
    localparam int DW = 144;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;

    joined_sample_board board;
    bit calm_phase = 1'b0;
    bit hold_off = 1'b0;
    logic [47:0] clock_now = '0;
    logic [47:0] gyro_clock = '0;
    logic [47:0] accel_clock = '0;

    imu_gyro_accel_time_aligner_core u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Offers one sample and holds it until the transaction completes.
    task automatic send_sample(logic hg, logic ha, logic [47:0] t,
                               logic signed [15:0] g[3], logic signed [15:0] a[3]);
        while (!calm_phase && $urandom_range(99) < 18) @(negedge i_clk);
        s_axis_tuser = {ha, hg};
        s_axis_tdata = {a[2], a[1], a[0], g[2], g[1], g[0], t};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_sample(hg, ha, t, g, a);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Sample with random vectors; extreme values show up now and then.
    task automatic send_random(logic hg, logic ha, logic [47:0] t);
        logic signed [15:0] g[3];
        logic signed [15:0] a[3];
        for (int k = 0; k < 3; k++) begin
            g[k] = ($urandom_range(9) == 0) ? 16'h8000 : 16'($urandom);
            a[k] = ($urandom_range(9) == 0) ? 16'h7fff : 16'($urandom);
        end
        send_sample(hg, ha, t, g, a);
    endtask

    // Sink: accepts and checks results, with random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_join(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !hold_off && (calm_phase || $urandom_range(99) >= 18);
    end

    // One long receiver hold-off while the sender keeps offering samples.
    initial begin
        repeat (3000) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic signed [15:0] gmax[3];
        logic signed [15:0] amin[3];
        int r;
        logic [47:0] t;
        board = new();
        gmax = '{16'sh7fff, 16'sh7fff, 16'sh7fff};
        amin = '{16'sh8000, 16'sh8000, 16'sh8000};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty sample, gyro at time zero, pass-through at extremes.
        send_random(1'b0, 1'b0, 48'd5);
        send_sample(1'b1, 1'b0, 48'd0, gmax, amin);
        send_sample(1'b0, 1'b1, 48'd0, gmax, amin);
        send_sample(1'b1, 1'b1, 48'd10, gmax, amin);
        send_sample(1'b1, 1'b1, 48'hffff_ffff_ffff, amin, gmax);
        send_sample(1'b1, 1'b1, 48'd20, amin, gmax);
        // Bracketing with extreme accel values, then equal time.
        send_sample(1'b0, 1'b1, 48'd100, gmax, amin);
        send_sample(1'b1, 1'b0, 48'd133, gmax, amin);
        send_sample(1'b0, 1'b1, 48'd200, gmax, gmax);
        send_sample(1'b1, 1'b0, 48'd200, amin, amin);
        // Stale gyro, no-bracket gyro, out-of-order and overflowing history.
        send_random(1'b1, 1'b0, 48'd150);
        send_random(1'b1, 1'b0, 48'd900);
        send_random(1'b0, 1'b1, 48'd50);
        for (int i = 0; i < 6; i++) send_random(1'b0, 1'b1, 48'd300 + 48'(i * 200));
        send_random(1'b0, 1'b1, 48'hffff_ffff_fff0);
        send_random(1'b1, 1'b0, 48'hffff_ffff_ff00);
        send_random(1'b0, 1'b1, 48'hffff_ffff_ffff);

        // Random: interleaved streams with rising times, some noise.
        clock_now = 48'd1000;
        gyro_clock = clock_now;
        accel_clock = clock_now;
        for (int i = 0; i < 1250; i++) begin
            calm_phase = (i >= 500 && i < 700);
            r = $urandom_range(99);
            if (r < 4) begin
                send_random(1'b1, 1'b1, gyro_clock);
            end else if (r < 6) begin
                send_random(1'b0, 1'b0, 48'({$urandom, $urandom}));
            end else if (r < 10) begin
                t = 48'({$urandom, $urandom});
                if ($urandom_range(1)) t = gyro_clock - 48'($urandom_range(50));
                send_random(1'($urandom_range(1)), 1'b0, t);
                send_random(1'b0, 1'b1, t);
            end else if (r < 55) begin
                gyro_clock += 48'($urandom_range(40));
                send_random(1'b1, 1'b0, gyro_clock);
            end else begin
                if ($urandom_range(19) == 0) accel_clock = gyro_clock;
                accel_clock += 48'($urandom_range(60));
                if ($urandom_range(29) == 0) accel_clock += 48'({$urandom, $urandom} >> 20);
                send_random(1'b0, 1'b1, accel_clock);
            end
            if (accel_clock > gyro_clock + 48'd500) gyro_clock = accel_clock - 48'd100;
        end

        // Drain, then allow the block's latency.
        calm_phase = 1'b1;
        while (board.pending_joins.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/imuta_pkg.sv
hw/rtl/imuta_frac_div.sv
hw/rtl/imu_gyro_accel_time_aligner_core.sv
verif/tb_imu_gyro_accel_time_aligner_core.sv
